// ----- hdl/vptc_pkg.sv -----
// Package with the types and constants shared by the valve pulse timer modules.
`timescale 1ns / 1ps

package vptc_pkg;

    localparam int NUM_VALVES = 3;
    localparam int DUR_W      = 16;
    localparam int TIME_W     = 32;

    // Input command codes.
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_FIRE_UPPER  = 2'd1;
    localparam logic [1:0] CMD_FIRE_LEFT   = 2'd2;
    localparam logic [1:0] CMD_FIRE_RIGHT  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_TICK   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_PULSE    = 1'b0;
    localparam logic CFG_MIN_COOLDOWN = 1'b1;

    // Configuration reset values.
    localparam logic [DUR_W-1:0] MAX_PULSE_RST    = 16'd1000;
    localparam logic [DUR_W-1:0] MIN_COOLDOWN_RST = 16'd4000;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [DUR_W-1:0] pulse_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            status;
        logic [NUM_VALVES-1:0] valve_outputs;
        logic                  pulse_active;
    } t_out_item;

    // Handshake control between the stages.
    typedef struct packed {
        logic valid;   // input stage holds a transaction
        logic advance; // result register can take a new result this cycle
    } t_stage_ctl;

endpackage

// ----- hdl/vptc_ireg.sv -----
// Input register stage of the valve pulse timer.
`timescale 1ns / 1ps

module vptc_ireg
    import vptc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_item   i_data,
    input  logic       i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output t_in_item   o_data
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_data;
    logic     take;

    // The register frees up whenever its item moves on to the result register.
    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/vptc_step.sv -----
// Timer state, configuration registers and the per-transaction update logic.
`timescale 1ns / 1ps

module vptc_step
    import vptc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [DUR_W-1:0] i_cfg_data,
    input  t_stage_ctl i_ctl,
    input  t_in_item   i_item,
    output t_out_item  o_result
);

    logic [DUR_W-1:0]      r_max_pulse;
    logic [DUR_W-1:0]      r_min_cool;
    logic [DUR_W-1:0]      r_rem [NUM_VALVES];
    logic [DUR_W-1:0]      n_rem [NUM_VALVES];
    logic [TIME_W-1:0]     r_time;
    logic [TIME_W-1:0]     n_time;
    logic [TIME_W-1:0]     r_last_end;
    logic [TIME_W-1:0]     n_last_end;
    logic                  r_ever_ended;
    logic                  n_ever_ended;
    logic [NUM_VALVES-1:0] r_valves;
    logic [NUM_VALVES-1:0] n_valves;

    logic                  fire;
    logic                  any_active;
    logic                  ended;
    logic                  allowed;
    logic [TIME_W-1:0]     since_end;
    logic [DUR_W-1:0]      dur;
    logic [DUR_W-1:0]      dec;
    logic [1:0]            status;
    logic                  is_tick;

    assign fire = i_ctl.valid && i_ctl.advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pulse <= MAX_PULSE_RST;
            r_min_cool  <= MIN_COOLDOWN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PULSE:    r_max_pulse <= i_cfg_data;
                CFG_MIN_COOLDOWN: r_min_cool  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign any_active = (r_rem[0] | r_rem[1] | r_rem[2]) != '0;
    assign since_end  = r_time - r_last_end;
    assign allowed    = !any_active &&
                        (!r_ever_ended || (since_end >= {{(TIME_W-DUR_W){1'b0}}, r_min_cool}));
    assign dur        = (i_item.pulse_ticks > r_max_pulse) ? r_max_pulse
                                                           : i_item.pulse_ticks;
    assign is_tick    = (i_item.cmd == CMD_TICK);

    always_comb begin
        n_time       = r_time;
        n_last_end   = r_last_end;
        n_ever_ended = r_ever_ended;
        n_valves     = r_valves;
        ended        = 1'b0;
        dec          = '0;
        for (int i = 0; i < NUM_VALVES; i++) begin
            n_rem[i] = r_rem[i];
        end

        if (is_tick) begin
            n_time = r_time + 1'b1;
            status = ST_TICK;
            for (int i = 0; i < NUM_VALVES; i++) begin
                dec = r_rem[i] - 1'b1;
                if (r_rem[i] != '0) begin
                    n_rem[i] = dec;
                    if (dec == '0) begin
                        n_valves[i] = 1'b0;
                        ended       = 1'b1;
                    end
                end
            end
            if (ended) begin
                n_last_end   = n_time;
                n_ever_ended = 1'b1;
            end
        end else if (allowed) begin
            status = ST_ACCEPT;
            for (int i = 0; i < NUM_VALVES; i++) begin
                if (i_item.cmd == 2'(i + 1)) begin
                    n_rem[i] = dur;
                    if (dur != '0) begin
                        n_valves[i] = 1'b1;
                    end
                end
            end
        end else begin
            status = ST_IGNORE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VALVES; i++) begin
                r_rem[i] <= '0;
            end
            r_time       <= '0;
            r_last_end   <= '0;
            r_ever_ended <= 1'b0;
            r_valves     <= '0;
        end else if (fire) begin
            for (int i = 0; i < NUM_VALVES; i++) begin
                r_rem[i] <= n_rem[i];
            end
            r_time       <= n_time;
            r_last_end   <= n_last_end;
            r_ever_ended <= n_ever_ended;
            r_valves     <= n_valves;
        end
    end

    always_comb begin
        o_result.status        = status;
        o_result.valve_outputs = n_valves;
        o_result.pulse_active  = (n_rem[0] | n_rem[1] | n_rem[2]) != '0;
    end

endmodule

// ----- hdl/vptc_oreg.sv -----
// Result register stage of the valve pulse timer.
`timescale 1ns / 1ps

module vptc_oreg
    import vptc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load_valid,
    input  t_out_item i_result,
    input  logic      i_stall,
    output logic      o_advance,
    output logic      o_valid,
    output t_out_item o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;
    logic      load;

    // The register can be reloaded when empty or when its result leaves now.
    assign o_advance = !r_valid || !i_stall;
    assign load      = i_load_valid && o_advance;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/valve_pulse_timer_with_cooldown.sv -----
// Top level of the three-valve pulse timer with cooldown lockout.
`timescale 1ns / 1ps

// The block drives three valves (upper, left, right) with timed one-shot pulses.
// Each input transaction is a tick or a fire request for one valve with a
// duration; each transaction produces exactly one result transaction carrying
// the status, the valve drive bits after the step and the pulse-active flag.
// Both channels use valid and stall: a transaction moves at a rising edge where
// valid is high and stall is low. The configuration port is a plain write port;
// index 0 is the maximum pulse length and index 1 the minimum cooldown. The user
// must write it only while no transaction is in flight; the block does not enforce it.
// An accepted transaction is held in the input register, its result is formed
// combinationally from it and loaded into the result register, and it leaves
// from there when the receiver does not stall. The state update is a single pass
// of logic between those registers (one 32-bit subtract and compare for the
// cooldown, three 16-bit decrements), so one transaction is accepted every
// cycle as long as the result side keeps taking results.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more transaction before the input stalls.
// Synchronous active-low reset closes all valves, clears the counters and the
// time base, and restores the configuration defaults of 1000 and 4000 ticks.

module valve_pulse_timer_with_cooldown
    import vptc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [DUR_W-1:0] i_cfg_data
);

    t_stage_ctl ctl;
    t_in_item   item;
    t_out_item  result;
    logic       item_valid;
    logic       advance;

    vptc_ireg u_ireg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (item_valid),
        .o_data    (item)
    );

    // The state advances exactly when the held item moves into the result register.
    assign ctl.valid   = item_valid;
    assign ctl.advance = advance;

    vptc_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .i_item     (item),
        .o_result   (result)
    );

    vptc_oreg u_oreg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (item_valid),
        .i_result     (result),
        .i_stall      (i_out_stall),
        .o_advance    (advance),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data)
    );

endmodule

// ----- hdl/vptc_chk.sv -----
// Port-level checks for the valve pulse timer and the bind that attaches them.
`timescale 1ns / 1ps

module vptc_chk
    import vptc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_ACCEPT ||
                         o_out_data.status == ST_IGNORE ||
                         o_out_data.status == ST_TICK))
        else $error("result status has an undefined code");

    a_idle_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pulse_active |-> o_out_data.valve_outputs == '0)
        else $error("valve open with no active pulse");

    a_one_valve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_data.valve_outputs))
        else $error("more than one valve open at once");

endmodule

bind valve_pulse_timer_with_cooldown vptc_chk u_vptc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
